// ===== rtl/afrb_pkg.sv =====
// Shared constants, types and helper functions for the audio frame ring buffer.
// Used by all modules of the block but afrb_ram, and by the channel interfaces.
package afrb_pkg;

  // Ring geometry
  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int DATA_W = 64;
  localparam int NREQ_W = 7;
  localparam int BA_W   = 4;
  localparam int CNT_W  = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd1;

  localparam logic [BA_W-1:0]  BA_RESET  = 4'd4;
  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE       = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ_UNREAD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_LAST   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY       = 2'd3;

  // Response queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_cmd_t;

  // Side information that travels alongside a memory read
  typedef struct packed {
    logic             valid;
    logic             status;
    logic             zero;
    logic             last;
    logic [CNT_W-1:0] unread;
  } tag_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_frame;
    logic              has_data;
    logic              last;
    logic [CNT_W-1:0]  unread_frames;
  } rsp_t;

  function automatic logic [DATA_W-1:0] frame_mask(input logic [BA_W-1:0] ba);
    logic [BA_W-1:0] b;
    b = (ba == '0) ? BA_W'(1) : ba;
    if (b >= BA_W'(8)) return '1;
    return (DATA_W'(1) << (8 * int'(b))) - DATA_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] raw);
    if (raw == '0) return CNT_W'(1);
    if (int'(raw) > DEPTH) return CNT_W'(DEPTH);
    return raw;
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [CNT_W-1:0] v);
    return ADDR_W'(v);
  endfunction

endpackage

// ===== rtl/afrb_if.sv =====
// Request and response channel interfaces of the audio frame ring buffer.
// Depends on afrb_pkg for field widths.
interface afrb_req_if;
  logic                               valid;
  logic                               ready;
  logic [afrb_pkg::REQ_W-1:0]         req_type;
  logic [afrb_pkg::DATA_W-1:0]        frame_data;
  logic                               zero_fill;
  logic [afrb_pkg::NREQ_W-1:0]        frame_count;

  modport source (output valid, req_type, frame_data, zero_fill, frame_count, input ready);
  modport sink (input valid, req_type, frame_data, zero_fill, frame_count, output ready);
endinterface

interface afrb_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [afrb_pkg::DATA_W-1:0]        out_frame;
  logic                               has_data;
  logic                               last;
  logic [afrb_pkg::CNT_W-1:0]         unread_frames;

  modport source (output valid, out_frame, has_data, last, unread_frames, input ready);
  modport sink (input valid, out_frame, has_data, last, unread_frames, output ready);
endinterface

// ===== rtl/audio_frame_ring_buffer_top.sv =====
// Top level of the audio frame ring buffer: sequencer, frame memory and
// response queue. Depends on afrb_pkg, afrb_if, afrb_ctrl, afrb_ram, afrb_rsp_fifo.
//
// Overwriting ring of audio frames held in a single-port frame memory of
// DEPTH 64-bit words. A write request returns one status transfer; a query
// likewise. A read request for n frames (n clamped to 64 and to the unread
// count or capacity) is first accepted, which computes the start position,
// then returns one frame per cycle while the response queue has room, limited
// by the single read port of the frame memory. A four-entry response queue
// keeps the memory reads streaming while the response side stalls, and new
// requests are taken while earlier responses still wait in the queue. Writing
// either config register clears the ring at once: instead of sweeping the
// memory, a fill count tracks how many entries were written since the clear,
// and entries beyond it read back as all-zero frames, so no clearing pass is
// needed. Config writes are expected only while the block is idle.
module audio_frame_ring_buffer_top (
  input  logic                                clk,
  input  logic                                rst,
  afrb_req_if.sink                            req,
  afrb_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [afrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afrb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  afrb_pkg::mem_cmd_t                 mem_cmd;
  afrb_pkg::tag_t                     tag;
  afrb_pkg::rsp_t                     push_data;
  logic [afrb_pkg::DATA_W-1:0]        rdata;
  logic [afrb_pkg::FIFO_LVL_W-1:0]    fifo_level;

  // Sequencer: owns pointers, counts and config; drives the memory
  afrb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_level (fifo_level),
    .mem_cmd    (mem_cmd),
    .tag        (tag)
  );

  // Frame memory: frames are masked to block_align bytes when written.
  // Reads are issued only in cycles with no write, so no forwarding is needed.
  afrb_ram #(
    .DEPTH (afrb_pkg::DEPTH),
    .WIDTH (afrb_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .re    (mem_cmd.re),
    .addr  (mem_cmd.addr),
    .wdata (mem_cmd.wdata),
    .rdata (rdata)
  );

  // Merge the tag with read data; status results and unfilled entries give zero
  always_comb begin
    push_data.out_frame     = (tag.status || tag.zero) ? '0 : rdata;
    push_data.has_data      = !tag.status;
    push_data.last          = tag.last;
    push_data.unread_frames = tag.unread;
  end

  afrb_rsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tag.valid),
    .push_data (push_data),
    .level     (fifo_level),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/afrb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No package dependency.
module afrb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/afrb_rsp_fifo.sv =====
// Small response queue that decouples memory reads from the response channel.
// Depends on afrb_pkg and afrb_rsp_if.
module afrb_rsp_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  afrb_pkg::rsp_t                   push_data,
  output logic [afrb_pkg::FIFO_LVL_W-1:0]  level,
  afrb_rsp_if.source                       rsp
);

  afrb_pkg::rsp_t                     slots [afrb_pkg::FIFO_DEPTH];
  logic [afrb_pkg::FIFO_PTR_W-1:0]    head;
  logic [afrb_pkg::FIFO_PTR_W-1:0]    tail;
  logic                               pop;
  afrb_pkg::rsp_t                     head_data;

  function automatic logic [afrb_pkg::FIFO_PTR_W-1:0] ptr_inc(
      input logic [afrb_pkg::FIFO_PTR_W-1:0] p);
    if (p == afrb_pkg::FIFO_PTR_W'(afrb_pkg::FIFO_DEPTH - 1)) return '0;
    return p + afrb_pkg::FIFO_PTR_W'(1);
  endfunction

  assign pop       = rsp.valid && rsp.ready;
  assign head_data = slots[head];

  assign rsp.valid         = (level != '0);
  assign rsp.out_frame     = head_data.out_frame;
  assign rsp.has_data      = head_data.has_data;
  assign rsp.last          = head_data.last;
  assign rsp.unread_frames = head_data.unread_frames;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        level <= level + afrb_pkg::FIFO_LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - afrb_pkg::FIFO_LVL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/afrb_ctrl.sv =====
// Request sequencer: ring pointers, unread and fill counts, configuration,
// and the frame memory command stream. Depends on afrb_pkg and afrb_req_if.
module afrb_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  afrb_req_if.sink                            req,
  input  logic                                cfg_we,
  input  logic [afrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afrb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [afrb_pkg::FIFO_LVL_W-1:0]     fifo_level,
  output afrb_pkg::mem_cmd_t                  mem_cmd,
  output afrb_pkg::tag_t                      tag
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                               state;
  logic [afrb_pkg::CNT_W-1:0]         wp;
  logic [afrb_pkg::CNT_W-1:0]         unread;
  logic [afrb_pkg::CNT_W-1:0]         filled;
  logic [afrb_pkg::CNT_W-1:0]         cap;
  logic [afrb_pkg::DATA_W-1:0]        mask;
  logic [afrb_pkg::CNT_W-1:0]         rd_pos;
  logic [afrb_pkg::NREQ_W-1:0]        rd_left;

  logic                               credit;
  logic                               accept;
  logic                               issue;
  logic [afrb_pkg::NREQ_W-1:0]        n_clamp;
  logic [afrb_pkg::CNT_W-1:0]         n_ext;
  logic [afrb_pkg::CNT_W-1:0]         nn_unread;
  logic [afrb_pkg::CNT_W-1:0]         nn_last;
  logic [afrb_pkg::CNT_W-1:0]         start_unread;
  logic [afrb_pkg::CNT_W-1:0]         start_last;
  logic [afrb_pkg::CNT_W-1:0]         wp_inc;
  logic [afrb_pkg::CNT_W-1:0]         rd_pos_inc;
  logic [afrb_pkg::CNT_W-1:0]         unread_inc;
  logic [afrb_pkg::CNT_W-1:0]         filled_inc;

  // Room for one more result, counting the read already in flight
  assign credit = (fifo_level + afrb_pkg::FIFO_LVL_W'(tag.valid))
                  < afrb_pkg::FIFO_LVL_W'(afrb_pkg::FIFO_DEPTH);
  assign req.ready = (state == S_IDLE) && credit;
  assign accept    = req.valid && req.ready;
  assign issue     = (state == S_READ) && credit;

  always_comb begin
    n_clamp = (req.frame_count > afrb_pkg::NREQ_W'(afrb_pkg::MAX_READ))
              ? afrb_pkg::NREQ_W'(afrb_pkg::MAX_READ) : req.frame_count;
    n_ext     = afrb_pkg::CNT_W'(n_clamp);
    nn_unread = (n_ext > unread) ? unread : n_ext;
    nn_last   = (n_ext > cap) ? cap : n_ext;
    start_unread = (wp >= unread) ? (wp - unread) : (wp + cap - unread);
    start_last   = (wp >= nn_last) ? (wp - nn_last) : (wp + cap - nn_last);
    wp_inc     = (wp + afrb_pkg::CNT_W'(1) == cap) ? '0 : wp + afrb_pkg::CNT_W'(1);
    rd_pos_inc = (rd_pos + afrb_pkg::CNT_W'(1) == cap) ? '0
                 : rd_pos + afrb_pkg::CNT_W'(1);
    unread_inc = (unread < cap) ? unread + afrb_pkg::CNT_W'(1) : cap;
    filled_inc = (filled < cap) ? filled + afrb_pkg::CNT_W'(1) : cap;
  end

  always_comb begin
    mem_cmd.we    = accept && (req.req_type == afrb_pkg::REQ_WRITE);
    mem_cmd.re    = issue;
    mem_cmd.addr  = mem_cmd.we ? afrb_pkg::to_addr(wp) : afrb_pkg::to_addr(rd_pos);
    mem_cmd.wdata = req.zero_fill ? '0 : (req.frame_data & mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      unread    <= '0;
      filled    <= '0;
      cap       <= afrb_pkg::eff_cap(afrb_pkg::CAP_RESET);
      mask      <= afrb_pkg::frame_mask(afrb_pkg::BA_RESET);
      tag.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tag.valid <= 1'b0;
        case (cfg_index)
          afrb_pkg::CFG_BLOCK_ALIGN: mask <= afrb_pkg::frame_mask(cfg_data[afrb_pkg::BA_W-1:0]);
          afrb_pkg::CFG_CAPACITY:    cap  <= afrb_pkg::eff_cap(afrb_pkg::CNT_W'(cfg_data));
          default: ;
        endcase
        wp     <= '0;
        unread <= '0;
        filled <= '0;
      end else if (accept) begin
        // Write, query and empty reads return one status transfer
        tag.status <= 1'b1;
        tag.zero   <= 1'b1;
        tag.last   <= 1'b1;
        case (req.req_type)
          afrb_pkg::REQ_WRITE: begin
            tag.valid  <= 1'b1;
            tag.unread <= unread_inc;
            wp         <= wp_inc;
            unread     <= unread_inc;
            filled     <= filled_inc;
          end
          afrb_pkg::REQ_READ_UNREAD: begin
            tag.valid  <= (nn_unread == '0);
            tag.unread <= unread;
            if (nn_unread != '0) begin
              state     <= S_READ;
              rd_pos    <= start_unread;
              rd_left   <= afrb_pkg::NREQ_W'(nn_unread);
              unread    <= unread - nn_unread;
            end
          end
          afrb_pkg::REQ_READ_LAST: begin
            tag.valid  <= (nn_last == '0);
            tag.unread <= unread;
            if (nn_last != '0) begin
              state     <= S_READ;
              rd_pos    <= start_last;
              rd_left   <= afrb_pkg::NREQ_W'(nn_last);
            end
          end
          default: begin
            tag.valid  <= 1'b1;
            tag.unread <= unread;
          end
        endcase
      end else if (issue) begin
        // Entries past the fill count were never written since the last clear
        tag.valid  <= 1'b1;
        tag.status <= 1'b0;
        tag.zero   <= (rd_pos >= filled);
        tag.last   <= (rd_left == afrb_pkg::NREQ_W'(1));
        tag.unread <= unread;
        rd_pos     <= rd_pos_inc;
        rd_left    <= rd_left - afrb_pkg::NREQ_W'(1);
        if (rd_left == afrb_pkg::NREQ_W'(1)) begin
          state <= S_IDLE;
        end
      end else begin
        tag.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for audio_frame_ring_buffer_top.
// Depends on afrb_pkg, afrb_req_if / afrb_rsp_if and the ring buffer RTL;
// holds its own ring model in a small scoreboard class.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afrb_pkg::*;

  // Run-length guard and post-drain settle time.
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 16;

  // Register settings, one per random phase. They cover the extremes and the
  // out-of-range codes (align 0 and above 8, capacity 0 and above DEPTH).
  localparam int N_PHASES   = 11;
  localparam int PHASE_ITEMS = 40;
  localparam int ALIGN_SET [N_PHASES] = '{8, 1, 0, 15, 3, 5, 2, 7, 6, 8, 4};
  localparam int CAP_SET   [N_PHASES] = '{1, 2, 0, 8191, 7, 4097, 4096, 16, 3, 33, 4096};

  // Ring model: mirrors the frame store, write pointer, unread count and both
  // registers, and keeps the frames/statuses the block still owes us.
  class frame_ring_model;
    logic [DATA_W-1:0] frames [DEPTH];
    int unsigned       head;
    int unsigned       unread;
    logic [BA_W-1:0]   align_reg;
    logic [CNT_W-1:0]  capacity_reg;
    rsp_t              owed[$];
    int                errors;

    function new();
      align_reg    = BA_RESET;
      capacity_reg = CAP_RESET;
      errors       = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      foreach (frames[i]) frames[i] = '0;
      head   = 0;
      unread = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_BLOCK_ALIGN) align_reg = value[BA_W-1:0];
      else capacity_reg = value[CNT_W-1:0];
      clear_ring();
    endfunction

    function int unsigned ring_size();
      if (capacity_reg == '0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return capacity_reg;
    endfunction

    // Keep only the bytes that belong to one frame.
    function logic [DATA_W-1:0] byte_mask();
      int nbytes;
      logic [DATA_W-1:0] m;
      nbytes = (align_reg == '0) ? 1 : ((align_reg > 8) ? 8 : int'(align_reg));
      m = '0;
      for (int i = 0; i < nbytes; i++) m[8*i +: 8] = 8'hFF;
      return m;
    endfunction

    function void owe_status();
      rsp_t r;
      r.out_frame     = '0;
      r.has_data      = 1'b0;
      r.last          = 1'b1;
      r.unread_frames = CNT_W'(unread);
      owed.push_back(r);
    endfunction

    function void owe_frames(int unsigned start, int unsigned n, int unsigned cap);
      rsp_t r;
      logic [DATA_W-1:0] m;
      int unsigned pos;
      m   = byte_mask();
      pos = start;
      for (int unsigned i = 0; i < n; i++) begin
        r.out_frame     = frames[pos % DEPTH] & m;
        r.has_data      = 1'b1;
        r.last          = (i + 1 == n);
        r.unread_frames = CNT_W'(unread);
        owed.push_back(r);
        pos = (pos + 1) % cap;
      end
    endfunction

    // Advance the model by one accepted request.
    function void take_request(logic [REQ_W-1:0] code, logic [DATA_W-1:0] data,
                               logic zero, logic [NREQ_W-1:0] count);
      int unsigned cap, wp, n, avail;
      cap = ring_size();
      wp  = head % cap;
      n   = (count > MAX_READ) ? MAX_READ : count;
      case (code)
        REQ_WRITE: begin
          frames[wp] = zero ? '0 : (data & byte_mask());
          head = (wp + 1) % cap;
          if (unread < cap) unread++;
          owe_status();
        end
        REQ_READ_UNREAD: begin
          avail = (unread > cap) ? cap : unread;
          if (n > avail) n = avail;
          if (n == 0) begin
            owe_status();
          end else begin
            unread = avail - n;
            owe_frames((wp + cap - avail) % cap, n, cap);
          end
        end
        REQ_READ_LAST: begin
          if (n > cap) n = cap;
          if (n == 0) owe_status();
          else owe_frames((wp + cap - n) % cap, n, cap);
        end
        default: owe_status();
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected transfer frame=%h has_data=%b last=%b unread=%0d",
                 $time, got.out_frame, got.has_data, got.last, got.unread_frames);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_frame !== want.out_frame) begin
        $display("%0t: out_frame expected %h actual %h", $time, want.out_frame, got.out_frame);
        errors++;
      end
      if (got.has_data !== want.has_data) begin
        $display("%0t: has_data expected %b actual %b", $time, want.has_data, got.has_data);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.unread_frames !== want.unread_frames) begin
        $display("%0t: unread_frames expected %0d actual %0d", $time,
                 want.unread_frames, got.unread_frames);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  afrb_req_if req_ch();
  afrb_rsp_if rsp_ch();

  frame_ring_model board;
  bit              idling;
  int              cycles;

  audio_frame_ring_buffer_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Sample both channels at the rising edge. Our own drives change on the
  // falling edge, and the block's outputs still hold their pre-edge values
  // here, so every transfer is seen exactly once.
  always @(posedge clk) begin
    rsp_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        board.take_request(req_ch.req_type, req_ch.frame_data, req_ch.zero_fill,
                           req_ch.frame_count);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.out_frame, rsp_ch.has_data, rsp_ch.last, rsp_ch.unread_frames};
        board.check_response(got);
      end
    end
  end

  // Response side: drop ready in random bursts while idling is on,
  // otherwise hold it high.
  initial begin
    int burst;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 10);
        rsp_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hard stop: a hung handshake or a missing response ends up here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Present one request, optionally after a random gap, and hold it until
  // the transfer happens. Valid stays high into the next call so that
  // back-to-back requests go out without a bubble.
  task automatic send_request(logic [REQ_W-1:0] code, logic [DATA_W-1:0] data,
                              logic zero, logic [NREQ_W-1:0] count);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= code;
    req_ch.frame_data  <= data;
    req_ch.zero_fill   <= zero;
    req_ch.frame_count <= count;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid, wait for every owed response, then let the pipeline settle.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, value);
  endtask

  // Random request: half writes, so unread frames pile up and reads have
  // something to drain; now and then a read far past the clamp limits.
  task automatic random_request();
    logic [REQ_W-1:0]  code;
    logic [DATA_W-1:0] data;
    logic [NREQ_W-1:0] count;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) code = REQ_WRITE;
    else if (pick < 7) code = REQ_READ_UNREAD;
    else if (pick < 9) code = REQ_READ_LAST;
    else code = REQ_QUERY;
    pick = $urandom_range(0, 9);
    if (pick == 0) data = '1;
    else if (pick == 1) data = '0;
    else data = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 0) count = $urandom_range(0, 127);
    else if (pick < 3) count = $urandom_range(0, 3);
    else count = $urandom_range(1, 12);
    send_request(code, data, ($urandom_range(0, 3) == 0), count);
  endtask

  initial begin
    board = new();
    idling = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_QUERY;
    req_ch.frame_data  = '0;
    req_ch.zero_fill   = 1'b0;
    req_ch.frame_count = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BLOCK_ALIGN;
    cfg_data  = '0;

    // Hold reset, then release it at a falling edge.
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (4-byte frames, full ring).
    // Empty ring: query, read unread with nothing unread, zero-length reads.
    send_request(REQ_QUERY,       '0, 1'b0, 7'd0);
    send_request(REQ_READ_UNREAD, '0, 1'b0, 7'd5);
    send_request(REQ_READ_LAST,   '0, 1'b0, 7'd0);
    send_request(REQ_READ_UNREAD, '0, 1'b0, 7'd0);
    // Writes: all ones (upper bytes must be masked off), zero fill over
    // non-zero data, all zeros, and two patterns.
    send_request(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'd127);
    send_request(REQ_WRITE, 64'hFEDC_BA98_7654_3210, 1'b1, 7'd0);
    send_request(REQ_WRITE, 64'h0000_0000_0000_0000, 1'b0, 7'd0);
    send_request(REQ_WRITE, 64'h0123_4567_89AB_CDEF, 1'b0, 7'd64);
    send_request(REQ_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 7'd1);
    send_request(REQ_QUERY, 64'h5555_5555_5555_5555, 1'b1, 7'd127);
    // Newest two, then an oversized read unread clamped to the unread count,
    // then read unread again with nothing left.
    send_request(REQ_READ_LAST,   '0, 1'b0, 7'd2);
    send_request(REQ_READ_UNREAD, '0, 1'b0, 7'd127);
    send_request(REQ_READ_UNREAD, '0, 1'b0, 7'd1);
    // Read last past what was written: clamps to 64, wraps the ring and
    // returns cleared entries as zero frames.
    send_request(REQ_READ_LAST,   '0, 1'b0, 7'd127);
    send_request(REQ_READ_LAST,   '0, 1'b0, 7'd64);
    send_request(REQ_WRITE, 64'h5555_5555_5555_5555, 1'b0, 7'd0);
    send_request(REQ_READ_UNREAD, '0, 1'b0, 7'd65);
    send_request(REQ_READ_LAST,   '0, 1'b0, 7'd1);

    // Random phases, one register setting each; the final phase runs with
    // both sides at full rate.
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      idling = (p != N_PHASES - 1);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_BLOCK_ALIGN, CFG_DATA_W'(ALIGN_SET[p]));
        write_reg(CFG_CAPACITY,    CFG_DATA_W'(CAP_SET[p]));
      end else begin
        write_reg(CFG_CAPACITY,    CFG_DATA_W'(CAP_SET[p]));
        write_reg(CFG_BLOCK_ALIGN, CFG_DATA_W'(ALIGN_SET[p]));
      end
      repeat (PHASE_ITEMS) random_request();
    end

    settle();
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== audio_frame_ring_buffer_top.f =====
rtl/afrb_pkg.sv
rtl/afrb_if.sv
rtl/afrb_ram.sv
rtl/afrb_rsp_fifo.sv
rtl/afrb_ctrl.sv
rtl/audio_frame_ring_buffer_top.sv
tb/tb_top.sv
